/* design/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned PAGE_PORT_W = 16;
  localparam int unsigned FRAME_IDX_W = 3;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned FIU_W       = 4;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = 4'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FRAMES_IN_USE = 2'd0;

  // result layout on the output tdata
  localparam int unsigned OUT_HIT_BIT   = 0;
  localparam int unsigned OUT_FRAME_LSB = 1;
  localparam int unsigned OUT_EVV_BIT   = 4;
  localparam int unsigned OUT_EVP_LSB   = 5;
  localparam int unsigned OUT_PAD_LSB   = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic hit_take;
    logic fill_take;
    logic sweep_init;
    logic sweep_clear;
    logic evict_rd;
    logic evict_take;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic free;
    logic ref_set;
    logic out_free;
  } status_t;

endpackage

/* design/cpr_ctrl.sv */
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer for one page reference: scan, fill or sweep, evict, deliver.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpr_pkg::status_t st_i,
  output cpr_pkg::cmd_t    cmd_o
);
  import cpr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (st_i.hit) begin
          state_d = ST_DONE;
        end else if (st_i.scan_end) begin
          state_d = st_i.free ? ST_DONE : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!st_i.ref_set) state_d = ST_EVICT;
      end
      ST_EVICT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.hit) begin
          cmd_o.hit_take = 1'b1;
        end else if (st_i.scan_end) begin
          cmd_o.fill_take  = st_i.free;
          cmd_o.sweep_init = !st_i.free;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_clear = st_i.ref_set;
        cmd_o.evict_rd    = !st_i.ref_set;
      end
      ST_EVICT: begin
        cmd_o.evict_take = 1'b1;
      end
      ST_DONE: begin
        cmd_o.push = st_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* design/cpr_dp.sv */
// ----------------------------------------------------------------------------
// cpr_dp
// Frame store, valid and reference bits, clock hand and output register.
// ----------------------------------------------------------------------------
module cpr_dp #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpr_pkg::cmd_t                     cmd_i,
  output cpr_pkg::status_t                  st_o,
  input  logic [cpr_pkg::FIU_W-1:0]         fiu_i,
  input  logic [cpr_pkg::PAGE_PORT_W-1:0]   in_page_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [cpr_pkg::OUT_DATA_W-1:0]    out_data_o
);
  import cpr_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int IW = (FW > FRAME_IDX_W) ? FW : FRAME_IDX_W;
  localparam int EW = (PAGE_BITS > PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;

  logic [PAGE_BITS-1:0] mem_q [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [FRAMES-1:0]    valid_q, ref_q;
  logic [FW-1:0]        hand_q, scan_q, cmp_q, free_idx_q, pos_q;
  logic                 rdv_q, free_fnd_q;

  logic                   res_hit_q, res_evv_q;
  logic [FRAME_IDX_W-1:0] res_frame_q;
  logic [PAGE_PORT_W-1:0] res_evp_q;

  logic                   out_valid_q, out_hit_q, out_evv_q;
  logic [FRAME_IDX_W-1:0] out_frame_q;
  logic [PAGE_PORT_W-1:0] out_evp_q;

  logic [FW-1:0]        last, sweep_start, fill_idx, mem_waddr, mem_raddr;
  logic [EW-1:0]        in_ext, ev_ext;
  logic [PAGE_BITS-1:0] in_page;
  logic [IW-1:0]        cmp_ext, fill_ext, pos_ext;
  logic                 mem_we, mem_re;

  function automatic logic [FW-1:0] next_pos(input logic [FW-1:0] p,
                                             input logic [FW-1:0] lst);
    next_pos = (p == lst) ? '0 : p + FW'(1);
  endfunction

  // last active frame, frame count clamped to 1 .. FRAMES
  always_comb begin
    if (fiu_i == '0) begin
      last = '0;
    end else if (int'(fiu_i) > FRAMES) begin
      last = FW'(FRAMES - 1);
    end else begin
      last = FW'(fiu_i - FIU_W'(1));
    end
  end

  assign in_ext      = EW'(in_page_i);
  assign in_page     = in_ext[PAGE_BITS-1:0];
  assign ev_ext      = EW'(rd_data_q);
  assign sweep_start = (hand_q > last) ? last : hand_q;
  assign fill_idx    = free_fnd_q ? free_idx_q : cmp_q;
  assign cmp_ext     = IW'(cmp_q);
  assign fill_ext    = IW'(fill_idx);
  assign pos_ext     = IW'(pos_q);

  assign st_o.hit      = rdv_q && valid_q[cmp_q] && (rd_data_q == page_q);
  assign st_o.scan_end = rdv_q && (cmp_q == last);
  assign st_o.free     = free_fnd_q || (rdv_q && !valid_q[cmp_q]);
  assign st_o.ref_set  = ref_q[pos_q];
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign mem_we    = cmd_i.fill_take || cmd_i.evict_take;
  assign mem_waddr = cmd_i.fill_take ? fill_idx : pos_q;
  assign mem_re    = cmd_i.scan || cmd_i.evict_rd;
  assign mem_raddr = cmd_i.evict_rd ? pos_q : scan_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= page_q;
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      rdv_q       <= 1'b0;
      free_fnd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rdv_q      <= 1'b0;
        free_fnd_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rdv_q <= 1'b1;
        if (rdv_q && !valid_q[cmp_q]) free_fnd_q <= 1'b1;
      end
      if (cmd_i.hit_take) begin
        ref_q[cmp_q] <= 1'b1;
      end else if (cmd_i.fill_take) begin
        valid_q[fill_idx] <= 1'b1;
        ref_q[fill_idx]   <= 1'b1;
        hand_q            <= fill_idx;
      end else if (cmd_i.sweep_clear) begin
        ref_q[pos_q] <= 1'b0;
      end else if (cmd_i.evict_take) begin
        ref_q[pos_q] <= 1'b1;
        hand_q       <= pos_q;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= in_page;
      scan_q <= '0;
    end else if (cmd_i.scan) begin
      cmp_q  <= scan_q;
      scan_q <= (scan_q == last) ? scan_q : scan_q + FW'(1);
      if (rdv_q && !valid_q[cmp_q] && !free_fnd_q) free_idx_q <= cmp_q;
    end
    if (cmd_i.sweep_init) begin
      pos_q <= next_pos(sweep_start, last);
    end else if (cmd_i.sweep_clear) begin
      pos_q <= next_pos(pos_q, last);
    end
    if (cmd_i.hit_take) begin
      res_hit_q   <= 1'b1;
      res_frame_q <= cmp_ext[FRAME_IDX_W-1:0];
      res_evv_q   <= 1'b0;
      res_evp_q   <= '0;
    end else if (cmd_i.fill_take) begin
      res_hit_q   <= 1'b0;
      res_frame_q <= fill_ext[FRAME_IDX_W-1:0];
      res_evv_q   <= 1'b0;
      res_evp_q   <= '0;
    end else if (cmd_i.evict_take) begin
      res_hit_q   <= 1'b0;
      res_frame_q <= pos_ext[FRAME_IDX_W-1:0];
      res_evv_q   <= 1'b1;
      res_evp_q   <= ev_ext[PAGE_PORT_W-1:0];
    end
    if (cmd_i.push) begin
      out_hit_q   <= res_hit_q;
      out_frame_q <= res_frame_q;
      out_evv_q   <= res_evv_q;
      out_evp_q   <= res_evp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_DATA_W - OUT_PAD_LSB)'(0), out_evp_q, out_evv_q,
                        out_frame_q, out_hit_q};

endmodule

/* design/clock_page_replacement.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement over up to FRAMES page frames.
// Flow: one reference at a time; the next is taken only once the outcome
//   of the last is in the output register. Time per reference is set by
//   the one-entry-per-cycle scan of the frame store and the reference-bit
//   sweep.
// Reset: frames empty, reference bits clear, hand at frame 0, frame count 3.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // page_number[15:0]
  input  logic [cpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hit[0], frame_index[3:1], evicted_valid[4], evicted_page[20:5], zero[23:21]
  output logic [cpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import cpr_pkg::*;

  logic [FIU_W-1:0] fiu_q;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          st;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_FRAMES_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_FRAMES_IN_USE) ? APB_DATA_W'(fiu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FIU_RESET;
    end else if (cfg_wr) begin
      fiu_q <= pwdata[FIU_W-1:0];
    end
  end

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .fiu_i       (fiu_q),
    .in_page_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* design/cpr_chk.sv */
// ----------------------------------------------------------------------------
// cpr_chk
// Port-level checks for clock_page_replacement, bound to the top level.
// ----------------------------------------------------------------------------
module cpr_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cpr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cpr_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OUT_HIT_BIT] && m_axis_tdata[OUT_EVV_BIT]))
    else $error("hit with eviction");

  // no eviction means a zero evicted page
  a_evp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OUT_EVV_BIT]
      |-> m_axis_tdata[OUT_PAD_LSB-1:OUT_EVP_LSB] == '0)
    else $error("evicted page set without eviction");

  // a new result only comes out of a busy cycle
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind clock_page_replacement cpr_chk u_cpr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* bench/page_ref_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_ref_checker
// Watches the page reference, outcome and register channels of
// clock_page_replacement. Keeps its own frame table, reference bits, clock
// hand and frame count, predicts the outcome of every accepted reference and
// compares each outcome transfer field by field, in order. Register reads of
// the frame count are compared as well.
// ----------------------------------------------------------------------------
module page_ref_checker
  import cpr_pkg::*;
#(
  parameter int FRAMES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    outstanding
);

  typedef struct {
    logic                             hit;
    logic [FRAME_IDX_W-1:0]           frame;
    logic                             ev_valid;
    logic [PAGE_PORT_W-1:0]           ev_page;
    logic [OUT_DATA_W-OUT_PAD_LSB-1:0] pad;
  } outcome_t;

  logic [PAGE_PORT_W-1:0] frame_page [FRAMES];
  logic                   frame_valid [FRAMES];
  logic                   ref_bit [FRAMES];
  int                     hand;
  logic [FIU_W-1:0]       frames_in_use;
  outcome_t               outcome_q [$];
  int                     mismatches;

  function automatic string fmt_outcome(input outcome_t o);
    return $sformatf("hit=%0d frame=%0d evicted=%0d page=%h pad=%h",
                     o.hit, o.frame, o.ev_valid, o.ev_page, o.pad);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatches++;
    mismatch_count = mismatches;
  endtask

  function automatic void load_frame(input int f, input logic [PAGE_PORT_W-1:0] page);
    frame_page[f]  = page;
    frame_valid[f] = 1'b1;
    ref_bit[f]     = 1'b1;
    hand           = f;
  endfunction

  // clock policy: hit, fill of the lowest empty frame, or second-chance sweep
  function automatic outcome_t predict_reference(input logic [PAGE_PORT_W-1:0] page);
    outcome_t res;
    int       n;
    int       f;
    int       pos;
    bit       found;
    res   = '{default: '0};
    n     = (frames_in_use == 0) ? 1 : ((frames_in_use > FRAMES) ? FRAMES : frames_in_use);
    f     = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (frame_valid[i] && frame_page[i] == page) begin
        f     = i;
        found = 1'b1;
        break;
      end
    end
    if (found) begin
      res.hit    = 1'b1;
      ref_bit[f] = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!frame_valid[i]) begin
          f     = i;
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        load_frame(f, page);
      end else begin
        pos = (hand < n) ? hand : n - 1;
        for (int s = 0; s < 2 * n + 1; s++) begin
          pos = (pos + 1 >= n) ? 0 : pos + 1;
          if (ref_bit[pos]) begin
            ref_bit[pos] = 1'b0;
          end else begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          pos = 0;
        end
        f            = pos;
        res.ev_valid = 1'b1;
        res.ev_page  = frame_page[f];
        load_frame(f, page);
      end
    end
    res.frame = f[FRAME_IDX_W-1:0];
    return res;
  endfunction

  initial begin
    mismatches     = 0;
    mismatch_count = 0;
    outstanding    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_valid[i] = 1'b0;
        ref_bit[i]     = 1'b0;
      end
      hand          = 0;
      frames_in_use = FIU_RESET;
      outcome_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pready && reg_idx_t'(paddr >> 2) == REG_FRAMES_IN_USE) begin
        if (pwrite) begin
          frames_in_use = pwdata[FIU_W-1:0];
        end else if (prdata !== APB_DATA_W'(frames_in_use)) begin
          note_mismatch($sformatf("frame count read: expected %h, got %h",
                                  APB_DATA_W'(frames_in_use), prdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(predict_reference(s_axis_tdata[PAGE_PORT_W-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.hit      = m_axis_tdata[OUT_HIT_BIT];
        seen.frame    = m_axis_tdata[OUT_FRAME_LSB +: FRAME_IDX_W];
        seen.ev_valid = m_axis_tdata[OUT_EVV_BIT];
        seen.ev_page  = m_axis_tdata[OUT_EVP_LSB +: PAGE_PORT_W];
        seen.pad      = m_axis_tdata[OUT_DATA_W-1:OUT_PAD_LSB];
        if (outcome_q.size() == 0) begin
          note_mismatch({"outcome with no reference pending: ", fmt_outcome(seen)});
        end else begin
          want = outcome_q.pop_front();
          if (seen.hit !== want.hit || seen.frame !== want.frame ||
              seen.ev_valid !== want.ev_valid || seen.ev_page !== want.ev_page ||
              seen.pad !== want.pad) begin
            note_mismatch({"outcome mismatch: expected ", fmt_outcome(want),
                           ", got ", fmt_outcome(seen)});
          end
        end
      end
      outstanding <= outcome_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the clock page replacement bench. Drives page references and the
// frame count register, stalls both stream sides at random, and reports the
// verdict from the checker's mismatch count. Directed references cover empty
// fills, hits, sweeps that clear every reference bit, out-of-range and zero
// frame counts, unmapped register writes, a hand left outside a shrunken
// frame set and duplicate residents; random phases follow at several counts.
// ----------------------------------------------------------------------------
module tb;
  import cpr_pkg::*;

  localparam int FRAMES          = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 40;
  localparam logic [APB_ADDR_W-1:0] FIU_ADDR = APB_ADDR_W'(REG_FRAMES_IN_USE) << 2;

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // page_number[15:0]
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // hit, frame_index[3:1], evicted_valid, evicted_page
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int outstanding;
  int idle_cycles;
  bit sender_gaps;
  bit receiver_stalls;

  clock_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_PORT_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  page_ref_checker #(
    .FRAMES (FRAMES)
  ) u_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (receiver_stalls) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_page(input logic [PAGE_PORT_W-1:0] page);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every outcome
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frames(input logic [FIU_W-1:0] count);
    drain();
    apb_access(1'b1, FIU_ADDR, {(APB_DATA_W - FIU_W)'($urandom() >> FIU_W), count});
    apb_access(1'b0, FIU_ADDR, '0);
  endtask

  initial begin
    logic [PAGE_PORT_W-1:0] pool [16];
    logic [FIU_W-1:0]       phase_counts [12];
    logic [PAGE_PORT_W-1:0] page;
    int                     pool_n;
    int                     active;
    int                     r;
    phase_counts  = '{4'd8, 4'd1, 4'd4, 4'd0, 4'd15, 4'd2, 4'd8, 4'd5, 4'd3, 4'd7, 4'd6, 4'd9};
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_cycles   = 0;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset frame count, fills, hits, full sweeps
    apb_access(1'b0, FIU_ADDR, '0);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h8001);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h7FFE);
    send_page(16'h0000);
    drain();
    // unmapped registers must leave the frame count alone
    for (int i = int'(REG_FRAMES_IN_USE) + 1; i < 4; i++) begin
      apb_access(1'b1, APB_ADDR_W'(i << 2), $urandom());
    end
    apb_access(1'b0, FIU_ADDR, '0);
    send_page(16'h8001);
    // zero count acts as one frame, hand left outside
    set_frames(4'd0);
    send_page(16'h7FFE);
    send_page(16'h1111);
    // oversized count acts as all frames
    set_frames(4'd15);
    send_page(16'h2222);
    send_page(16'h3333);
    send_page(16'h4444);
    send_page(16'h5555);
    send_page(16'h6666);
    // shrink, reload a page that stays resident above the count
    set_frames(4'd2);
    send_page(16'h5555);
    set_frames(4'd8);
    send_page(16'h5555);
    send_page(16'h6666);
    set_frames(4'd9);
    send_page(16'hABCD);
    send_page(16'h5555);
    set_frames(4'd1);
    send_page(16'h5555);
    send_page(16'h0000);

    // random phases over a small working set with noise
    for (int ph = 0; ph < 12; ph++) begin
      set_frames(phase_counts[ph]);
      sender_gaps     = ph[0];
      receiver_stalls = ph[1];
      active = (phase_counts[ph] == 0) ? 1 :
               ((phase_counts[ph] > FRAMES) ? FRAMES : int'(phase_counts[ph]));
      pool_n = active + $urandom_range(0, 4);
      for (int i = 0; i < pool_n; i++) pool[i] = PAGE_PORT_W'($urandom());
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          page = pool[$urandom_range(0, pool_n - 1)];
        end else if (r < 84) begin
          page = r[0] ? 16'h0000 : 16'hFFFF;
        end else begin
          page = PAGE_PORT_W'($urandom());
        end
        send_page(page);
        if (k == ITEMS_PER_PHASE / 2) begin
          drain();
          pool[$urandom_range(0, pool_n - 1)] = PAGE_PORT_W'($urandom());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
